/* sv/swc_pkg.sv */
package swc_pkg;

	// Default number of bytes that fill a command line
	localparam int LINE_LENGTH_DEF = 20;

	// Only the first bytes of a line can decide a match: longest word plus its terminator
	localparam int PREFIX_LEN = 7;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_NUL  = 8'h00;

	// Limits of the time cascade
	localparam logic [6:0] CENTI_LAST = 7'd99;
	localparam logic [5:0] SEC_LAST   = 6'd59;
	localparam logic [5:0] MIN_LAST   = 6'd59;

	typedef logic [7:0] char_t;
	typedef char_t [PREFIX_LEN-1:0] prefix_t;

	typedef enum logic [2:0] {
		EV_TICK    = 3'd0,
		EV_START   = 3'd1,
		EV_STOP    = 3'd2,
		EV_SPLIT1  = 3'd3,
		EV_SPLIT2  = 3'd4,
		EV_RESET   = 3'd5,
		EV_HELP    = 3'd6,
		EV_UNKNOWN = 3'd7
	} event_t;

	typedef struct packed {
		logic [6:0] centis;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [7:0] hours;
	} stamp_t;

	// Command words, first character in the lowest byte
	localparam prefix_t WORD_START  = {CHAR_NUL, CHAR_NUL, "t", "r", "a", "t", "s"};
	localparam prefix_t WORD_STOP   = {CHAR_NUL, CHAR_NUL, CHAR_NUL, "p", "o", "t", "s"};
	localparam prefix_t WORD_SPLIT1 = {CHAR_NUL, "1", "t", "i", "l", "p", "s"};
	localparam prefix_t WORD_SPLIT2 = {CHAR_NUL, "2", "t", "i", "l", "p", "s"};
	localparam prefix_t WORD_RESET  = {CHAR_NUL, CHAR_NUL, "t", "e", "s", "e", "r"};
	localparam prefix_t WORD_HELP   = {CHAR_NUL, CHAR_NUL, CHAR_NUL, "p", "l", "e", "h"};

	localparam int LEN_START  = 5;
	localparam int LEN_STOP   = 4;
	localparam int LEN_SPLIT  = 6;
	localparam int LEN_RESET  = 5;
	localparam int LEN_HELP   = 4;

endpackage

/* sv/swc_cmd_match.sv */
module swc_cmd_match #(
	parameter int LINE_LENGTH = swc_pkg::LINE_LENGTH_DEF
) (
	input  swc_pkg::prefix_t                   text,
	input  logic [$clog2(LINE_LENGTH)-1:0]     len,
	output swc_pkg::event_t                    ev
);
	import swc_pkg::*;

	localparam int LEN_W = $clog2(LINE_LENGTH);

	// True when the line text, cut at its first zero byte, equals the word
	function automatic logic word_hit(input prefix_t txt, input logic [LEN_W-1:0] n,
			input prefix_t word, input int wlen);
		logic hit;
		hit = (n >= LEN_W'(wlen));
		for (int i = 0; i < PREFIX_LEN; i++) begin
			if (i < wlen) begin
				if (txt[i] != word[i])
					hit = 1'b0;
			end else if (i == wlen) begin
				if (n != LEN_W'(wlen) && txt[i] != CHAR_NUL)
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

	// Decode the line into its command
	always_comb begin
		if (word_hit(text, len, WORD_START, LEN_START))
			ev = EV_START;
		else if (word_hit(text, len, WORD_STOP, LEN_STOP))
			ev = EV_STOP;
		else if (word_hit(text, len, WORD_SPLIT1, LEN_SPLIT))
			ev = EV_SPLIT1;
		else if (word_hit(text, len, WORD_SPLIT2, LEN_SPLIT))
			ev = EV_SPLIT2;
		else if (word_hit(text, len, WORD_RESET, LEN_RESET))
			ev = EV_RESET;
		else if (word_hit(text, len, WORD_HELP, LEN_HELP))
			ev = EV_HELP;
		else
			ev = EV_UNKNOWN;
	end

endmodule

/* sv/stopwatch_with_text_commands.sv */
// Stopwatch with a serial command line. Each request on the slave side is either a
// centisecond tick (s_tuser = 0) or a received character (s_tuser = 1, byte in s_tdata).
// A tick while running advances centiseconds, seconds, minutes and hours (hours wrap at
// 256) and returns the new time with event 0. Characters collect into a line that ends
// at a carriage return or when LINE_LENGTH characters are stored; the line, cut at its
// first zero byte, is matched against start, stop, split1, split2, reset and help, and
// one result carries the command code (7 for anything else) and the time after its
// effect. Ticks while halted and characters that do not end a line give no result.
// An item passes through the input register and then the result register; a new request
// is taken every cycle, and only a result that waits for m_tready holds the next item
// that produces a result.
module stopwatch_with_text_commands #(
	parameter int LINE_LENGTH = swc_pkg::LINE_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] hours, [13:8] minutes, [19:14] seconds,
	                               // [26:20] centiseconds, [31:27] zero
	output logic [2:0]  m_tuser    // [2:0] event_res
);
	import swc_pkg::*;

	localparam int LEN_W = $clog2(LINE_LENGTH);

	// Input register
	logic        v_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;

	// Watch and line state
	logic             running_q;
	stamp_t           stamp_q;
	logic [LEN_W-1:0] len_q;
	prefix_t          text_q;

	// Result register
	logic    m_valid_q;
	event_t  ev_q;
	stamp_t  res_q;

	logic    is_cr, is_store, line_full, do_eval, do_tick, has_res, go;
	event_t  cmd_ev;
	event_t  ev_next;
	stamp_t  stamp_next;
	logic    running_next;

	swc_cmd_match #(.LINE_LENGTH(LINE_LENGTH)) u_match (
		.text (text_q),
		.len  (len_q),
		.ev   (cmd_ev)
	);

	// Classify the held item
	assign is_cr     = op_s1 && (byte_s1 == CHAR_CR);
	assign is_store  = op_s1 && !is_cr;
	assign line_full = is_store && (len_q == LEN_W'(LINE_LENGTH - 1));
	assign do_eval   = is_cr || line_full;
	assign do_tick   = !op_s1 && running_q;
	assign has_res   = do_tick || do_eval;
	assign go        = v_s1 && (!has_res || !m_valid_q || m_tready);
	assign s_tready  = !v_s1 || go;

	// Next time, run flag and event
	always_comb begin
		stamp_next   = stamp_q;
		running_next = running_q;
		ev_next      = EV_TICK;
		if (do_tick) begin
			if (stamp_q.centis == CENTI_LAST) begin
				stamp_next.centis = '0;
				if (stamp_q.seconds == SEC_LAST) begin
					stamp_next.seconds = '0;
					if (stamp_q.minutes == MIN_LAST) begin
						stamp_next.minutes = '0;
						stamp_next.hours   = stamp_q.hours + 8'd1;
					end else begin
						stamp_next.minutes = stamp_q.minutes + 6'd1;
					end
				end else begin
					stamp_next.seconds = stamp_q.seconds + 6'd1;
				end
			end else begin
				stamp_next.centis = stamp_q.centis + 7'd1;
			end
		end else if (do_eval) begin
			ev_next = cmd_ev;
			if (cmd_ev == EV_START) begin
				running_next = 1'b1;
			end else if (cmd_ev == EV_STOP) begin
				running_next = 1'b0;
			end else if (cmd_ev == EV_RESET) begin
				running_next = 1'b0;
				stamp_next   = '0;
			end
		end
	end

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Advance watch and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b1;
			stamp_q   <= '0;
			len_q     <= '0;
		end else if (go) begin
			running_q <= running_next;
			stamp_q   <= stamp_next;
			if (do_eval)
				len_q <= '0;
			else if (is_store)
				len_q <= len_q + LEN_W'(1);
		end
	end

	// Store the leading characters; later ones never decide a match
	always_ff @(posedge clk) begin
		if (go && is_store) begin
			for (int i = 0; i < PREFIX_LEN; i++) begin
				if (len_q == LEN_W'(i))
					text_q[i] <= byte_s1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go && has_res) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_res) begin
			ev_q  <= ev_next;
			res_q <= stamp_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = ev_q;
	assign m_tdata  = {5'd0, res_q.centis, res_q.seconds, res_q.minutes, res_q.hours};

	// A held item stays until it can move on
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !go |=> v_s1)
		else $error("input item lost while stalled");

	// Reported time stays inside the cascade limits
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (res_q.centis <= CENTI_LAST) && (res_q.seconds <= SEC_LAST)
			&& (res_q.minutes <= MIN_LAST))
		else $error("time field out of range");

	// Line fill never reaches the full length between items
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_LENGTH - 1))
		else $error("line length overflow");

	// A reset command reports a cleared time
	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (ev_q == EV_RESET) |-> (res_q == '0))
		else $error("reset command reported nonzero time");

	// A tick while halted changes nothing
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		go && !op_s1 && !running_q |=> $stable(stamp_q) && !running_q)
		else $error("halted watch advanced");

endmodule

/* bench/stopwatch_cmd_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the stopwatch, predicts every report from the requests it
// sees and compares each report that leaves the block with the oldest prediction.
module stopwatch_cmd_checker #(
	parameter int LINE_LENGTH = swc_pkg::LINE_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [7:0] hours, [13:8] minutes, [19:14] seconds,
	                               // [26:20] centiseconds, [31:27] zero
	input  logic [2:0]  m_tuser,   // [2:0] event_res
	output int          fail_count,
	output int          pending
);
	import swc_pkg::*;

	typedef struct {
		event_t     ev;
		logic [7:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [6:0] centis;
	} report_t;

	// Reports predicted but not yet seen on the master side
	report_t report_q[$];

	// Own copy of the watch and the command line
	logic       watch_on;
	logic [6:0] cs_cnt;
	logic [5:0] sec_cnt;
	logic [5:0] min_cnt;
	logic [7:0] hr_cnt;
	char_t      line_buf [LINE_LENGTH];
	int         line_fill;
	int         mismatches;

	// Compare the stored text, cut at its first zero byte, with one command word
	function automatic bit text_equals(int tlen, string word);
		if (tlen != word.len()) begin
			return 1'b0;
		end
		for (int i = 0; i < tlen; i++) begin
			if (line_buf[i] != word[i]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Match the line, apply the command and clear the line
	function automatic event_t run_command();
		int     tlen;
		event_t ev;
		tlen = 0;
		while (tlen < line_fill && line_buf[tlen] != CHAR_NUL) begin
			tlen++;
		end
		if (text_equals(tlen, "start")) begin
			ev = EV_START;
		end else if (text_equals(tlen, "stop")) begin
			ev = EV_STOP;
		end else if (text_equals(tlen, "split1")) begin
			ev = EV_SPLIT1;
		end else if (text_equals(tlen, "split2")) begin
			ev = EV_SPLIT2;
		end else if (text_equals(tlen, "reset")) begin
			ev = EV_RESET;
		end else if (text_equals(tlen, "help")) begin
			ev = EV_HELP;
		end else begin
			ev = EV_UNKNOWN;
		end
		case (ev)
			EV_START: begin
				watch_on = 1'b1;
			end
			EV_STOP: begin
				watch_on = 1'b0;
			end
			EV_RESET: begin
				watch_on = 1'b0;
				cs_cnt   = '0;
				sec_cnt  = '0;
				min_cnt  = '0;
				hr_cnt   = '0;
			end
			default: begin
			end
		endcase
		line_fill = 0;
		return ev;
	endfunction

	// Advance the time by one centisecond with a full carry chain
	function automatic void count_centisecond();
		if (cs_cnt == CENTI_LAST) begin
			cs_cnt = '0;
			if (sec_cnt == SEC_LAST) begin
				sec_cnt = '0;
				if (min_cnt == MIN_LAST) begin
					min_cnt = '0;
					hr_cnt  = hr_cnt + 8'd1;
				end else begin
					min_cnt = min_cnt + 6'd1;
				end
			end else begin
				sec_cnt = sec_cnt + 6'd1;
			end
		end else begin
			cs_cnt = cs_cnt + 7'd1;
		end
	endfunction

	// Apply one request; return 1 when it produces a report
	function automatic bit step_watch(logic op, char_t rx, output report_t rep);
		event_t ev;
		if (op == 1'b0) begin
			if (!watch_on) begin
				return 1'b0;
			end
			count_centisecond();
			ev = EV_TICK;
		end else if (rx == CHAR_CR) begin
			ev = run_command();
		end else begin
			if (line_fill >= LINE_LENGTH) begin
				line_fill = 0;
			end
			line_buf[line_fill] = rx;
			line_fill++;
			if (line_fill < LINE_LENGTH) begin
				return 1'b0;
			end
			ev = run_command();
		end
		rep.ev      = ev;
		rep.hours   = hr_cnt;
		rep.minutes = min_cnt;
		rep.seconds = sec_cnt;
		rep.centis  = cs_cnt;
		return 1'b1;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Retire reports first, then predict, so a stray report never meets a fresh prediction
	always @(posedge clk or negedge arst_n) begin
		report_t want_r;
		report_t new_r;
		if (!arst_n) begin
			watch_on   = 1'b1;
			cs_cnt     = '0;
			sec_cnt    = '0;
			min_cnt    = '0;
			hr_cnt     = '0;
			line_fill  = 0;
			mismatches = 0;
			report_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					$error("report with no request pending: event %0d", m_tuser);
					mismatches++;
				end else begin
					want_r = report_q.pop_front();
					check_field("event_res", want_r.ev, m_tuser);
					check_field("hours", want_r.hours, m_tdata[7:0]);
					check_field("minutes", want_r.minutes, m_tdata[13:8]);
					check_field("seconds", want_r.seconds, m_tdata[19:14]);
					check_field("centiseconds", want_r.centis, m_tdata[26:20]);
					check_field("padding", 0, m_tdata[31:27]);
				end
			end
			if (s_tvalid && s_tready) begin
				if (step_watch(s_tuser, s_tdata, new_r)) begin
					report_q.push_back(new_r);
				end
			end
			pending    <= report_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* bench/stopwatch_with_text_commands_test.sv */
`timescale 1ns / 100ps

module stopwatch_with_text_commands_test;
	import swc_pkg::*;

	localparam int LINE_LEN    = LINE_LENGTH_DEF;
	localparam int ITEM_GOAL   = 1450;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_RUN    = 150;
	localparam int END_CYCLES  = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	int fail_count;
	int pending;
	int sent       = 0;
	int send_calm  = 0;
	bit hold_req   = 1'b0;
	bit hold_done  = 1'b0;

	// Bytes of the line being built for the next command
	logic [7:0] line_q[$];

	always #6 clk = ~clk;

	stopwatch_with_text_commands #(
		.LINE_LENGTH(LINE_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	stopwatch_cmd_checker #(
		.LINE_LENGTH(LINE_LEN)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Offer one request after a random gap and hold it until accepted
	task automatic push_item(input logic op, input logic [7:0] rx);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			if ($urandom_range(0, 63) == 0) begin
				send_calm = $urandom_range(10, 60);
			end
			gap = $urandom_range(0, 16);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= rx;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic push_ticks(input int count);
		repeat (count) push_item(1'b0, 8'($urandom_range(0, 255)));
	endtask

	task automatic add_word(input string w);
		for (int i = 0; i < w.len(); i++) begin
			line_q.push_back(w[i]);
		end
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
		return b;
	endfunction

	// Send the built line, optionally closed by a carriage return
	task automatic push_line(input bit with_cr);
		foreach (line_q[i]) begin
			push_item(1'b1, line_q[i]);
		end
		if (with_cr) begin
			push_item(1'b1, CHAR_CR);
		end
		line_q.delete();
	endtask

	task automatic push_command(input string w);
		add_word(w);
		push_line(1'b1);
	endtask

	// Lower the request and wait until every predicted report has left the block
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Favor start and splits so the watch keeps running most of the time
	function automatic string pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			return "start";
		end else if (r < 42) begin
			return "stop";
		end else if (r < 62) begin
			return "split1";
		end else if (r < 82) begin
			return "split2";
		end else if (r < 95) begin
			return "help";
		end
		return "reset";
	endfunction

	// Take reports after a random wait; hold off for a long stretch on request
	initial begin : receiver
		int gap;
		int recv_calm;
		recv_calm = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (recv_calm > 0) begin
				gap = 0;
				recv_calm--;
			end else begin
				if ($urandom_range(0, 63) == 0) begin
					recv_calm = $urandom_range(10, 60);
				end
				gap = $urandom_range(0, 16);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// End the run when nothing moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int kind;
		int n;
		int pos;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Tick while running, with the ignored byte at its top value
		push_item(1'b0, 8'hFF);
		push_command("stop");
		// Tick while halted
		push_item(1'b0, 8'h00);
		// Empty line
		push_item(1'b1, CHAR_CR);
		// Zero byte ends the text early
		add_word("help");
		line_q.push_back(CHAR_NUL);
		add_word("x");
		push_line(1'b1);
		line_q.push_back(8'hFF);
		push_line(1'b1);
		push_command("reset");
		push_command("start");
		push_item(1'b0, 8'h55);
		drain();

		while (sent < ITEM_GOAL) begin
			// Fill the block while the receiver holds off, then pause until drained
			if (!hold_done && sent >= ITEM_GOAL / 2) begin
				push_command("start");
				hold_req  = 1'b1;
				send_calm = 40;
				push_ticks(40);
				drain();
				hold_done = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				push_ticks($urandom_range(1, 30));
			end else if (kind < 62) begin
				push_command(pick_word());
			end else if (kind < 72) begin
				n = $urandom_range(0, LINE_LEN - 1);
				repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
				push_line(1'b1);
			end else if (kind < 80) begin
				// Full line with no carriage return, sometimes a word cut by a zero byte
				if ($urandom_range(0, 1) == 1) begin
					add_word(pick_word());
					line_q.push_back(CHAR_NUL);
				end
				while (line_q.size() < LINE_LEN) line_q.push_back(plain_byte());
				push_line(1'b0);
			end else if (kind < 88) begin
				// Near miss of a command word
				add_word(pick_word());
				case ($urandom_range(0, 2))
					0: begin
						void'(line_q.pop_back());
					end
					1: begin
						line_q.push_back(plain_byte());
					end
					default: begin
						pos = $urandom_range(0, line_q.size() - 1);
						line_q[pos] = 8'($urandom_range(0, 255));
					end
				endcase
				push_line(1'b1);
			end else if (kind < 95) begin
				add_word(pick_word());
				line_q.push_back(CHAR_NUL);
				repeat ($urandom_range(0, 5)) line_q.push_back(plain_byte());
				push_line(1'b1);
			end else begin
				push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end

		// Run long enough to carry into the seconds
		push_command("start");
		send_calm = LONG_RUN;
		push_ticks(LONG_RUN);
		push_command("split1");

		drain();
		repeat (END_CYCLES) @(posedge clk);
		@(negedge clk);
		if (pending != 0) begin
			$error("%0d reports never arrived", pending);
		end
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
